@@ sv/best_fit_block_allocator_top_defines.svh @@
// Assertion macros shared by the allocator RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define BFA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BFA_ASSERT_IMPL(lbl, ante, cons, msg)

`define BFA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/bfa_pkg.sv @@
// Shared types and constants for the best-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int ADDR_BITS      = 24;
	localparam int REG_BITS       = ADDR_BITS + 1;
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int CFG_IDX_BITS   = 2;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [ADDR_BITS:0]   bsize_t;
	typedef logic [REG_BITS-1:0]  reg_t;

	typedef struct packed {
		addr_t  start;
		bsize_t size;
	} blk_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_NOFIT    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CLEAR,
		OP_INIT,
		OP_WRITE,
		OP_INSERT,
		OP_REMOVE
	} tbl_op_t;

	typedef struct packed {
		tbl_op_t op;
		blk_t    blk;
	} tbl_cmd_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MEM_SIZE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MEM_START = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MEM_ALIGN = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

endpackage

@@ sv/best_fit_block_allocator_top.sv @@
// Best-fit block allocator with coalescing: the free and used block tables live in two
// synchronous memories with registered reads, and each scan walks a table one entry per cycle.
// An allocate first rounds the size up to the alignment granule when one is set (bit-serial
// remainder), then scans the free table and updates both tables. A free makes one pass over the
// used table, one over the free table, then the shifts that close and open table slots, which
// run side by side. Reset and every write to a defined register rebuild the pool in S_INIT;
// requests are held off meanwhile. The next request is taken as soon as the previous
// result is in the output register.
`timescale 1ns / 1ps

`include "best_fit_block_allocator_top_defines.svh"

module best_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bfa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  bfa_pkg::reg_t                        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  bfa_pkg::reg_t                        req_size,
	input  bfa_pkg::addr_t                       block_addr,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bfa_pkg::status_t                     status,
	output bfa_pkg::addr_t                       block_start,
	output bfa_pkg::bsize_t                      block_size
);
	import bfa_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = ADDR_BITS + 2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DIV,
		S_ASCAN,
		S_AUPD,
		S_USCAN,
		S_FSCAN,
		S_FUPD,
		S_FREM,
		S_WAIT,
		S_RESP
	} state_t;

	state_t        state_q;
	reg_t          mem_size_q;
	reg_t          mem_start_q;
	reg_t          mem_align_q;
	reg_t          eff_start_q;

	reg_t          req_q;
	addr_t         addr_q;
	logic [REG_BITS:0] size_q;
	logic          found_q;
	blk_t          best_q;
	logic [AW-1:0] best_idx_q;
	logic [AW-1:0] uj_q;
	blk_t          blk_q;
	logic          has_prev_q;
	logic          has_next_q;
	blk_t          prev_q;
	blk_t          next_q;
	logic [CW-1:0] p_q;

	logic [CW-1:0] iss_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;

	status_t       res_status_q;
	addr_t         res_start_q;
	bsize_t        res_size_q;
	logic          out_valid_q;
	status_t       out_status_q;
	addr_t         out_start_q;
	bsize_t        out_size_q;

	tbl_cmd_t      fcmd;
	tbl_cmd_t      ucmd;
	logic [AW-1:0] fpos;
	logic [AW-1:0] upos;
	logic          f_rd_en;
	logic          u_rd_en;
	blk_t          f_rd;
	blk_t          u_rd;
	logic [CW-1:0] f_cnt;
	logic [CW-1:0] u_cnt;
	logic          f_busy;
	logic          u_busy;

	logic          div_start;
	logic          div_done;
	reg_t          div_rem;

	reg_t          lim_end;
	reg_t          lim_start;
	logic          scan_state;
	logic [CW-1:0] scan_cnt;
	logic          scan_issue;
	logic          scan_done;
	blk_t          scan_rd;
	logic          mprev;
	logic          mnext;
	logic          in_acc;
	logic          cfg_acc;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;
	assign div_start = in_acc && action == ACT_ALLOC && req_size != '0 && mem_align_q != '0;

	always_comb begin
		lim_end   = (mem_size_q > reg_t'(1 << ADDR_BITS)) ? reg_t'(1 << ADDR_BITS) : mem_size_q;
		lim_start = (mem_start_q < lim_end) ? mem_start_q : lim_end;
	end

	always_comb begin
		scan_state = (state_q == S_ASCAN) || (state_q == S_USCAN) || (state_q == S_FSCAN);
		scan_cnt   = (state_q == S_USCAN) ? u_cnt : f_cnt;
		scan_issue = scan_state && (iss_q < scan_cnt);
		scan_done  = scan_state && !scan_issue && !pend_s1;
		scan_rd    = (state_q == S_USCAN) ? u_rd : f_rd;
		f_rd_en    = scan_issue && (state_q != S_USCAN);
		u_rd_en    = scan_issue && (state_q == S_USCAN);
	end

	always_comb begin
		mprev = has_prev_q && (SW'(prev_q.start) + SW'(prev_q.size) == SW'(blk_q.start));
		mnext = has_next_q && (SW'(blk_q.start) + SW'(blk_q.size) == SW'(next_q.start));
	end

	always_comb begin
		fcmd.op  = OP_NOP;
		fcmd.blk = '0;
		fpos     = '0;
		ucmd.op  = OP_NOP;
		ucmd.blk = '0;
		upos     = '0;
		unique case (state_q)
			S_INIT: begin
				fcmd.op        = (lim_start < lim_end) ? OP_INIT : OP_CLEAR;
				fcmd.blk.start = addr_t'(lim_start);
				fcmd.blk.size  = bsize_t'(lim_end - lim_start);
				ucmd.op        = (lim_start != '0) ? OP_INIT : OP_CLEAR;
				ucmd.blk.size  = bsize_t'(lim_start);
			end
			S_AUPD: begin
				fpos = best_idx_q;
				if ({1'b0, best_q.size} == size_q) begin
					fcmd.op = OP_REMOVE;
				end else begin
					fcmd.op        = OP_WRITE;
					fcmd.blk.start = addr_t'(best_q.start + size_q[ADDR_BITS-1:0]);
					fcmd.blk.size  = bsize_t'(best_q.size - size_q[ADDR_BITS:0]);
				end
				ucmd.op        = OP_INSERT;
				ucmd.blk.start = best_q.start;
				ucmd.blk.size  = size_q[ADDR_BITS:0];
			end
			S_FUPD: begin
				ucmd.op = OP_REMOVE;
				upos    = uj_q;
				if (mprev) begin
					fcmd.op        = OP_WRITE;
					fpos           = AW'(p_q - CW'(1));
					fcmd.blk.start = prev_q.start;
					if (mnext)
						fcmd.blk.size = bsize_t'(prev_q.size + blk_q.size + next_q.size);
					else
						fcmd.blk.size = bsize_t'(prev_q.size + blk_q.size);
				end else if (mnext) begin
					fcmd.op        = OP_WRITE;
					fpos           = p_q[AW-1:0];
					fcmd.blk.start = blk_q.start;
					fcmd.blk.size  = bsize_t'(next_q.size + blk_q.size);
				end else begin
					fcmd.op  = OP_INSERT;
					fcmd.blk = blk_q;
				end
			end
			S_FREM: begin
				// Both neighbors merged: drop the upper one
				fcmd.op = OP_REMOVE;
				fpos    = p_q[AW-1:0];
			end
			default: ;
		endcase
	end

	bfa_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_free_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (fcmd),
		.cmd_pos (fpos),
		.rd_en   (f_rd_en),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (f_rd),
		.count   (f_cnt),
		.busy    (f_busy)
	);

	bfa_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_used_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ucmd),
		.cmd_pos (upos),
		.rd_en   (u_rd_en),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (u_rd),
		.count   (u_cnt),
		.busy    (u_busy)
	);

	bfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req_size),
		.divisor  (mem_align_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			mem_size_q   <= reg_t'(1 << ADDR_BITS);
			mem_start_q  <= '0;
			mem_align_q  <= '0;
			eff_start_q  <= '0;
			req_q        <= '0;
			addr_q       <= '0;
			size_q       <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_idx_q   <= '0;
			uj_q         <= '0;
			blk_q        <= '0;
			has_prev_q   <= 1'b0;
			has_next_q   <= 1'b0;
			prev_q       <= '0;
			next_q       <= '0;
			p_q          <= '0;
			iss_q        <= '0;
			pend_s1      <= 1'b0;
			idx_s1       <= '0;
			res_status_q <= ST_OK;
			res_start_q  <= '0;
			res_size_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_start_q  <= '0;
			out_size_q   <= '0;
		end else begin
			pend_s1 <= scan_issue;
			idx_s1  <= iss_q[AW-1:0];
			if (scan_issue)
				iss_q <= iss_q + CW'(1);
			if (out_valid_q && out_ready && state_q != S_RESP)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_INIT: begin
					eff_start_q <= lim_start;
					state_q     <= S_IDLE;
				end
				S_IDLE: begin
					iss_q   <= '0;
					found_q <= 1'b0;
					if (cfg_acc) begin
						unique case (cfg_index)
							CFG_MEM_SIZE: begin
								mem_size_q <= cfg_data;
								state_q    <= S_INIT;
							end
							CFG_MEM_START: begin
								mem_start_q <= cfg_data;
								state_q     <= S_INIT;
							end
							CFG_MEM_ALIGN: begin
								mem_align_q <= cfg_data;
								state_q     <= S_INIT;
							end
							default: ;
						endcase
					end else if (in_acc) begin
						req_q       <= req_size;
						addr_q      <= block_addr;
						res_start_q <= '0;
						res_size_q  <= '0;
						if (action == ACT_FREE) begin
							state_q <= S_USCAN;
						end else if (req_size == '0) begin
							res_status_q <= ST_ZERO;
							state_q      <= S_RESP;
						end else if (mem_align_q == '0) begin
							size_q  <= {1'b0, req_size};
							state_q <= S_ASCAN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_rem == '0)
							size_q <= {1'b0, req_q};
						else
							size_q <= {1'b0, req_q} + {1'b0, mem_align_q} - {1'b0, div_rem};
						state_q <= S_ASCAN;
					end
				end
				S_ASCAN: begin
					// Strictly smaller wins, so the earliest of equal sizes is kept
					if (pend_s1 && ({1'b0, scan_rd.size} >= size_q)
							&& (!found_q || scan_rd.size < best_q.size)) begin
						found_q    <= 1'b1;
						best_q     <= scan_rd;
						best_idx_q <= idx_s1;
					end
					if (scan_done) begin
						if (!found_q) begin
							res_status_q <= ST_NOFIT;
							state_q      <= S_RESP;
						end else if (u_cnt >= CW'(MAX_BLOCKS)) begin
							res_status_q <= ST_FULL;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_AUPD;
						end
					end
				end
				S_AUPD: begin
					res_status_q <= ST_OK;
					res_start_q  <= best_q.start;
					res_size_q   <= size_q[ADDR_BITS:0];
					state_q      <= S_WAIT;
				end
				S_USCAN: begin
					if (pend_s1 && !found_q && scan_rd.start == addr_q) begin
						found_q <= 1'b1;
						uj_q    <= idx_s1;
						blk_q   <= scan_rd;
					end
					if (scan_done) begin
						iss_q      <= '0;
						has_prev_q <= 1'b0;
						has_next_q <= 1'b0;
						p_q        <= '0;
						if (!found_q || reg_t'(blk_q.start) < eff_start_q) begin
							res_status_q <= ST_NOTFOUND;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_FSCAN;
						end
					end
				end
				S_FSCAN: begin
					if (pend_s1) begin
						if (scan_rd.start < blk_q.start) begin
							has_prev_q <= 1'b1;
							prev_q     <= scan_rd;
							p_q        <= CW'(idx_s1) + CW'(1);
						end else if (!has_next_q) begin
							has_next_q <= 1'b1;
							next_q     <= scan_rd;
						end
					end
					if (scan_done) begin
						if (!mprev && !mnext && f_cnt >= CW'(MAX_BLOCKS)) begin
							res_status_q <= ST_FULL;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_FUPD;
						end
					end
				end
				S_FUPD: begin
					res_status_q <= ST_OK;
					res_start_q  <= blk_q.start;
					res_size_q   <= blk_q.size;
					state_q      <= (mprev && mnext) ? S_FREM : S_WAIT;
				end
				S_FREM: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!f_busy && !u_busy)
						state_q <= S_RESP;
				end
				S_RESP: begin
					// Hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_start_q  <= res_start_q;
						out_size_q   <= res_size_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign block_start = out_start_q;
	assign block_size  = out_size_q;

	`BFA_ASSERT_IMPL(a_err_zero_payload, out_valid && status != ST_OK,
		block_start == '0 && block_size == '0, "error result carries a block")
	`BFA_ASSERT_IMPL(a_idle_tables_quiet, in_ready, !f_busy && !u_busy,
		"request taken while a table is shifting")
	`BFA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q != S_IDLE,
		"accepted request did not start")

endmodule

@@ sv/bfa_div.sv @@
// Bit-serial remainder unit: one dividend bit per cycle.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bfa_pkg::reg_t dividend,
	input  bfa_pkg::reg_t divisor,
	output logic          done,
	output bfa_pkg::reg_t rem
);
	import bfa_pkg::*;

	localparam int CNT_W = $clog2(REG_BITS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	reg_t             rem_q;
	reg_t             num_q;
	reg_t             den_q;
	logic [REG_BITS:0] trial;

	always_comb begin
		trial = {rem_q, num_q[REG_BITS-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(REG_BITS);
				busy_q <= 1'b1;
				rem_q  <= '0;
				num_q  <= dividend;
				den_q  <= divisor;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q})
					rem_q <= REG_BITS'(trial - {1'b0, den_q});
				else
					rem_q <= REG_BITS'(trial);
				num_q <= {num_q[REG_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ sv/bfa_table.sv @@
// Sorted block table: one synchronous memory plus a shift engine for insert and remove.
// Depends on bfa_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "best_fit_block_allocator_top_defines.svh"

module bfa_table #(
	parameter  int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
	localparam int AW = $clog2(MAX_BLOCKS),
	localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfa_pkg::tbl_cmd_t cmd,
	input  logic [AW-1:0]     cmd_pos,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output bfa_pkg::blk_t     rd_data,
	output logic [CW-1:0]     count,
	output logic              busy
);
	import bfa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_INS_LAST,
		S_REM
	} tstate_t;

	tstate_t       state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] k_q;
	blk_t          key_q;
	blk_t          rd_q;
	blk_t          mem [MAX_BLOCKS];

	logic          we;
	logic [AW-1:0] wa;
	blk_t          wd;
	logic          re;
	logic [AW-1:0] ra;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = cmd.blk;
		re = 1'b0;
		ra = rd_addr;
		unique case (state_q)
			S_IDLE: begin
				re = rd_en;
				unique case (cmd.op)
					OP_INIT: begin
						we = 1'b1;
					end
					OP_WRITE: begin
						we = 1'b1;
						wa = cmd_pos;
					end
					OP_INSERT: begin
						if (count_q == '0) begin
							we = 1'b1;
						end else begin
							re = 1'b1;
							ra = AW'(count_q - CW'(1));
						end
					end
					OP_REMOVE: begin
						if (CW'(cmd_pos) + CW'(1) < count_q) begin
							re = 1'b1;
							ra = cmd_pos + AW'(1);
						end
					end
					default: ;
				endcase
			end
			S_INS: begin
				// Move entries up until the slot for the key is found
				we = 1'b1;
				wa = k_q + AW'(1);
				if (rd_q.start < key_q.start) begin
					wd = key_q;
				end else begin
					wd = rd_q;
					if (k_q != '0) begin
						re = 1'b1;
						ra = k_q - AW'(1);
					end
				end
			end
			S_INS_LAST: begin
				we = 1'b1;
				wd = key_q;
			end
			S_REM: begin
				we = 1'b1;
				wa = k_q - AW'(1);
				wd = rd_q;
				if (CW'(k_q) + CW'(1) < count_q) begin
					re = 1'b1;
					ra = k_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.op == OP_INSERT)
			key_q <= cmd.blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					unique case (cmd.op)
						OP_CLEAR: count_q <= '0;
						OP_INIT:  count_q <= CW'(1);
						OP_INSERT: begin
							if (count_q == '0) begin
								count_q <= CW'(1);
							end else begin
								k_q     <= AW'(count_q - CW'(1));
								state_q <= S_INS;
							end
						end
						OP_REMOVE: begin
							if (CW'(cmd_pos) + CW'(1) < count_q) begin
								k_q     <= cmd_pos + AW'(1);
								state_q <= S_REM;
							end else begin
								count_q <= count_q - CW'(1);
							end
						end
						default: ;
					endcase
				end
				S_INS: begin
					if (rd_q.start < key_q.start) begin
						count_q <= count_q + CW'(1);
						state_q <= S_IDLE;
					end else if (k_q == '0) begin
						state_q <= S_INS_LAST;
					end else begin
						k_q <= k_q - AW'(1);
					end
				end
				S_INS_LAST: begin
					count_q <= count_q + CW'(1);
					state_q <= S_IDLE;
				end
				S_REM: begin
					if (CW'(k_q) + CW'(1) < count_q) begin
						k_q <= k_q + AW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rd_data = rd_q;
	assign count   = count_q;
	assign busy    = (state_q != S_IDLE);

	`BFA_ASSERT_IMPL(a_tbl_count_max, 1'b1, count_q <= CW'(MAX_BLOCKS), "table count over depth")
	`BFA_ASSERT_IMPL(a_tbl_ins_room, state_q == S_IDLE && cmd.op == OP_INSERT,
		count_q < CW'(MAX_BLOCKS), "insert into full table")
	`BFA_ASSERT_IMPL(a_tbl_rem_pos, state_q == S_IDLE && cmd.op == OP_REMOVE,
		CW'(cmd_pos) < count_q, "remove past last entry")

endmodule

@@ test/best_fit_block_allocator_checker.sv @@
// Scoreboard for the best-fit block allocator: tracks register writes, keeps its own
// free and used tables, predicts each result and compares it with the output beat.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module best_fit_block_allocator_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [bfa_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  bfa_pkg::reg_t                    cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             action,
	input  bfa_pkg::reg_t                    req_size,
	input  bfa_pkg::addr_t                   block_addr,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  bfa_pkg::status_t                 status,
	input  bfa_pkg::addr_t                   block_start,
	input  bfa_pkg::bsize_t                  block_size,
	output int                               errors,
	output int                               pending
);
	import bfa_pkg::*;

	localparam int DEPTH = MAX_BLOCKS_DEF;
	localparam longint SPAN_MAX = longint'(1) << ADDR_BITS;

	typedef struct {
		status_t st;
		addr_t   start;
		bsize_t  size;
	} grant_t;

	reg_t   region_end;
	reg_t   region_base;
	reg_t   granule;
	longint base_eff;
	longint free_s[DEPTH];
	longint free_z[DEPTH];
	longint used_s[DEPTH];
	longint used_z[DEPTH];
	int     free_n;
	int     used_n;
	grant_t grants_q[$];

	assign pending = grants_q.size();

	function automatic void rebuild_pool();
		longint e, s;
		e = (longint'(region_end) < SPAN_MAX) ? longint'(region_end) : SPAN_MAX;
		s = (longint'(region_base) < e) ? longint'(region_base) : e;
		base_eff = s;
		free_n = 0;
		used_n = 0;
		if (s < e) begin
			free_s[0] = s;
			free_z[0] = e - s;
			free_n = 1;
		end
		if (s > 0) begin
			used_s[0] = 0;
			used_z[0] = s;
			used_n = 1;
		end
	endfunction

	function automatic grant_t carve_block(reg_t req);
		grant_t g;
		longint need;
		int best, pos;
		g = '{ST_OK, '0, '0};
		best = -1;
		if (req == 0) begin
			g.st = ST_ZERO;
			return g;
		end
		need = longint'(req);
		if (granule != 0)
			need = ((need + longint'(granule) - 1) / longint'(granule)) * longint'(granule);
		for (int i = 0; i < free_n; i++)
			if (free_z[i] >= need && (best < 0 || free_z[i] < free_z[best]))
				best = i;
		if (best < 0) begin
			g.st = ST_NOFIT;
			return g;
		end
		if (used_n >= DEPTH) begin
			g.st = ST_FULL;
			return g;
		end
		g.start = addr_t'(free_s[best]);
		g.size = bsize_t'(need);
		pos = 0;
		while (pos < used_n && used_s[pos] < free_s[best])
			pos++;
		for (int i = used_n; i > pos; i--) begin
			used_s[i] = used_s[i-1];
			used_z[i] = used_z[i-1];
		end
		used_s[pos] = free_s[best];
		used_z[pos] = need;
		used_n++;
		if (free_z[best] == need) begin
			for (int i = best; i < free_n - 1; i++) begin
				free_s[i] = free_s[i+1];
				free_z[i] = free_z[i+1];
			end
			free_n--;
		end else begin
			free_s[best] += need;
			free_z[best] -= need;
		end
		return g;
	endfunction

	function automatic grant_t release_block(addr_t addr);
		grant_t g;
		longint bs, bz;
		int j, p;
		bit join_lo, join_hi;
		g = '{ST_NOTFOUND, '0, '0};
		j = 0;
		while (j < used_n && used_s[j] != longint'(addr))
			j++;
		if (j >= used_n)
			return g;
		bs = used_s[j];
		bz = used_z[j];
		// the reserved block below the base is never released
		if (bs < base_eff)
			return g;
		p = 0;
		while (p < free_n && free_s[p] < bs)
			p++;
		join_lo = p > 0 && free_s[p-1] + free_z[p-1] == bs;
		join_hi = p < free_n && bs + bz == free_s[p];
		if (!join_lo && !join_hi && free_n >= DEPTH) begin
			g.st = ST_FULL;
			return g;
		end
		for (int i = j; i < used_n - 1; i++) begin
			used_s[i] = used_s[i+1];
			used_z[i] = used_z[i+1];
		end
		used_n--;
		if (join_lo && join_hi) begin
			free_z[p-1] += bz + free_z[p];
			for (int i = p; i < free_n - 1; i++) begin
				free_s[i] = free_s[i+1];
				free_z[i] = free_z[i+1];
			end
			free_n--;
		end else if (join_lo) begin
			free_z[p-1] += bz;
		end else if (join_hi) begin
			free_s[p] = bs;
			free_z[p] += bz;
		end else begin
			for (int i = free_n; i > p; i--) begin
				free_s[i] = free_s[i-1];
				free_z[i] = free_z[i-1];
			end
			free_s[p] = bs;
			free_z[p] = bz;
			free_n++;
		end
		g = '{ST_OK, addr_t'(bs), bsize_t'(bz)};
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		grant_t got;
		if (!arst_n) begin
			region_end = reg_t'(SPAN_MAX);
			region_base = '0;
			granule = '0;
			rebuild_pool();
			grants_q.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (grants_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, status %0d start %0d size %0d",
						$time, status, block_start, block_size);
					errors++;
				end else begin
					want = grants_q.pop_front();
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						errors++;
					end
					if (block_start !== want.start) begin
						$display("%0t: block_start expected %0d actual %0d",
							$time, want.start, block_start);
						errors++;
					end
					if (block_size !== want.size) begin
						$display("%0t: block_size expected %0d actual %0d",
							$time, want.size, block_size);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MEM_SIZE:  region_end = cfg_data;
					CFG_MEM_START: region_base = cfg_data;
					CFG_MEM_ALIGN: granule = cfg_data;
					default:       ;
				endcase
				if (cfg_index == CFG_MEM_SIZE || cfg_index == CFG_MEM_START ||
						cfg_index == CFG_MEM_ALIGN)
					rebuild_pool();
			end
			if (in_valid && in_ready) begin
				got = (action == ACT_ALLOC) ? carve_block(req_size) : release_block(block_addr);
				grants_q = {grants_q, got};
			end
		end
	end

endmodule

@@ test/best_fit_block_allocator_top_test.sv @@
// Stimulus and verdict for the best-fit block allocator: directed corner requests, then
// random allocate/free traffic over several pool settings with bursty input and output stalls.
// Depends on bfa_pkg, best_fit_block_allocator_top and best_fit_block_allocator_checker.
`timescale 1ns / 1ps

module best_fit_block_allocator_top_test;
	import bfa_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 400;
	localparam reg_t REG_MAX = '1;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	reg_t                    cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    action;
	reg_t                    req_size;
	addr_t                   block_addr;
	logic                    out_valid;
	logic                    out_ready;
	status_t                 status;
	addr_t                   block_start;
	bsize_t                  block_size;
	int                      errors;
	int                      pending;

	int    sent_n;
	int    done_n;
	int    burst_left;
	int    phases_run;
	logic  act_q[$];
	addr_t live_q[$];
	int    ok_allocs;
	int    ok_frees;

	best_fit_block_allocator_top dut (.*);

	best_fit_block_allocator_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

	// track granted blocks so that frees can target live addresses
	always @(posedge clk) begin
		logic was_alloc;
		if (arst_n && out_valid && out_ready) begin
			was_alloc = act_q.pop_front();
			done_n++;
			if (status == ST_OK) begin
				if (was_alloc == ACT_ALLOC) begin
					live_q = {live_q, block_start};
					ok_allocs++;
				end else begin
					ok_frees++;
				end
			end
		end
	end

	// receiver: random stall pattern, plus one long hold-off once traffic is flowing
	initial begin
		int mode, left;
		bit held;
		out_ready = 1'b0;
		held = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			left = $urandom_range(20, 200);
			repeat (left) begin
				@(negedge clk);
				if (!held && sent_n >= 150) begin
					held = 1;
					out_ready <= 1'b0;
					repeat (3000) @(negedge clk);
				end
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_beat(logic act, reg_t sz, addr_t addr);
		bit taken;
		@(negedge clk);
		action <= act;
		req_size <= sz;
		block_addr <= addr;
		in_valid <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = in_ready;
		end
		act_q = {act_q, act};
		sent_n++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 10);
		end
	endtask

	task automatic drain();
		while (done_n != sent_n || pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, reg_t val);
		bit taken;
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = cfg_ready;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pool(reg_t sz, reg_t base, reg_t gran);
		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		write_reg(CFG_MEM_SIZE, sz);
		write_reg(CFG_MEM_START, base);
		write_reg(CFG_MEM_ALIGN, gran);
		live_q.delete();
		phases_run++;
	endtask

	task automatic random_traffic(int count, int span);
		int pick, idx;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_beat(ACT_ALLOC, reg_t'($urandom_range(1, span > 32 ? span / 24 : 2)),
					addr_t'($urandom));
			else if (pick < 55)
				send_beat(ACT_ALLOC, reg_t'($urandom), addr_t'($urandom));
			else if (pick < 57)
				send_beat(ACT_ALLOC, '0, addr_t'($urandom));
			else if (pick < 59)
				send_beat(ACT_ALLOC, REG_MAX, '0);
			else if (pick < 88 && live_q.size() > 0) begin
				idx = $urandom_range(0, live_q.size() - 1);
				send_beat(ACT_FREE, reg_t'($urandom), live_q[idx]);
				live_q.delete(idx);
			end else if (pick < 92)
				send_beat(ACT_FREE, '0, '0);
			else
				send_beat(ACT_FREE, reg_t'($urandom), addr_t'($urandom_range(0, span)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MEM_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_ALLOC;
		req_size = '0;
		block_addr = '0;
		sent_n = 0;
		done_n = 0;
		burst_left = 0;
		phases_run = 0;
		ok_allocs = 0;
		ok_frees = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset pool, whole region, zero and oversized requests
		send_beat(ACT_ALLOC, '0, '0);
		send_beat(ACT_ALLOC, REG_MAX, '0);
		send_beat(ACT_ALLOC, reg_t'(1 << ADDR_BITS), '0);
		send_beat(ACT_ALLOC, reg_t'(1), '0);
		send_beat(ACT_FREE, '0, '0);
		send_beat(ACT_FREE, '0, '0);
		send_beat(ACT_FREE, REG_MAX, '1);
		// reserved region, alignment and merges on both sides
		set_pool(reg_t'(200), reg_t'(100), reg_t'(8));
		send_beat(ACT_FREE, '0, '0);
		send_beat(ACT_ALLOC, reg_t'(3), '0);
		send_beat(ACT_ALLOC, reg_t'(9), '0);
		send_beat(ACT_ALLOC, reg_t'(8), '0);
		send_beat(ACT_ALLOC, reg_t'(200), '0);
		send_beat(ACT_FREE, '0, addr_t'(108));
		send_beat(ACT_FREE, '0, addr_t'(100));
		send_beat(ACT_FREE, '0, addr_t'(124));
		send_beat(ACT_FREE, '0, addr_t'(124));
		send_beat(ACT_ALLOC, reg_t'(100), '0);
		send_beat(ACT_ALLOC, reg_t'(1), '0);
		// saturated end, base past end: empty pool
		set_pool(REG_MAX, REG_MAX, REG_MAX);
		send_beat(ACT_ALLOC, reg_t'(1), '0);
		send_beat(ACT_FREE, '0, '0);
		send_beat(ACT_FREE, '0, '1);

		// fill the used table with unit blocks, then free every other one
		set_pool(reg_t'(1000), '0, '0);
		repeat (66) send_beat(ACT_ALLOC, reg_t'(1), '0);
		for (int a = 0; a < 64; a += 2)
			send_beat(ACT_FREE, '0, addr_t'(a));
		random_traffic(40, 1000);

		set_pool(reg_t'(1 << ADDR_BITS), '0, '0);
		random_traffic(100, 1 << ADDR_BITS);
		set_pool(reg_t'(4096), reg_t'(512), reg_t'(16));
		random_traffic(100, 4096);
		set_pool(reg_t'(300), '0, reg_t'(1));
		random_traffic(80, 300);
		set_pool(reg_t'(1 << ADDR_BITS), reg_t'(1000), reg_t'(3));
		random_traffic(80, 1 << 16);
		set_pool(reg_t'(2000), reg_t'(5000), '0);
		random_traffic(15, 6000);
		set_pool('0, '0, '0);
		random_traffic(15, 64);
		set_pool(reg_t'(1 << 20), reg_t'(7), reg_t'(5));
		random_traffic(100, 1 << 12);

		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		$display("%0d requests over %0d pool settings: %0d blocks granted, %0d released",
			sent_n, phases_run, ok_allocs, ok_frees);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
